// ----- rtl/core/dpsf_pkg.sv -----
package dpsf_pkg;

   localparam int NUM_TERMS      = 4;
   localparam int NUM_ROUNDS     = NUM_TERMS - 1;
   localparam int MAX_TERM_DEF   = 4;
   localparam int FIRST_TERM_DEF = 1;

   localparam int Z_W     = 16;
   localparam int BS_W    = 16;
   localparam int ZL_W    = 15;
   localparam int IW_W    = 24;
   localparam int U_W     = 32;
   localparam int PW_W    = 48;
   localparam int RAD_W   = 64;
   localparam int ROOT_W  = 32;
   localparam int NUM_W   = 79;
   localparam int DEN_W   = 37;
   localparam int SLOPE_W = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [PW_W-1:0] PW_CAP = 48'h8000_0000_0000;
   localparam logic [63:0]     DT_CAP = 64'h1000_0000_0000_0000;
   localparam logic [PW_W-1:0] ONE_Q16 = 48'd65536;

   localparam logic [BS_W-1:0] BASE_SIGMA_RST = 16'd3404;
   localparam logic [ZL_W-1:0] Z_LIMIT_RST    = 15'd1000;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_BASE_SIGMA  = 3'd0,
      REG_FOCUS_Z     = 3'd1,
      REG_Z_LIMIT     = 3'd2,
      REG_INV_ONE     = 3'd3,
      REG_INV_TWO     = 3'd4,
      REG_INV_THREE   = 3'd5,
      REG_INV_FOUR    = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [NUM_W-1:0] num;
      logic             dneg;
      logic             szero;
      logic             clamped;
      logic             inr;
   } sqrt_side_type;

   typedef struct packed {
      logic [BS_W-1:0] width;
      logic            dneg;
      logic            zero;
      logic            ovf;
      logic            clamped;
      logic            inr;
   } div_side_type;

endpackage

// ----- rtl/core/dpsf_sqrt.sv -----
module dpsf_sqrt (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  logic                             in_valid,
   input  logic [dpsf_pkg::RAD_W-1:0]       radicand,
   input  dpsf_pkg::sqrt_side_type          in_side,
   output logic                             out_valid,
   output logic [dpsf_pkg::ROOT_W-1:0]      root,
   output dpsf_pkg::sqrt_side_type          out_side
);

   localparam int N  = dpsf_pkg::ROOT_W;
   localparam int RW = dpsf_pkg::RAD_W;

   logic [N:0]    v_ff;
   logic [RW-1:0] rem_ff  [0:N];
   logic [N-1:0]  root_ff [0:N];
   dpsf_pkg::sqrt_side_type side_ff [0:N];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
      end
      if (en) begin
         rem_ff[0]  <= radicand;
         root_ff[0] <= '0;
         side_ff[0] <= in_side;
      end
   end

   // one root bit per stage, remainder form so no squaring
   for (genvar j = 0; j < N; j++) begin : g_step
      localparam int B = N - 1 - j;
      logic [RW+1:0] trial;
      logic          take;
      assign trial = ({(RW + 2 - N)'(0), root_ff[j]} << (B + 1)) + ((RW + 2)'(1) << (2 * B));
      assign take  = {2'b00, rem_ff[j]} >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j+1] <= 1'b0;
         end else if (en) begin
            v_ff[j+1] <= v_ff[j];
         end
         if (en) begin
            rem_ff[j+1]  <= take ? rem_ff[j] - trial[RW-1:0] : rem_ff[j];
            root_ff[j+1] <= take ? root_ff[j] | (N'(1) << B) : root_ff[j];
            side_ff[j+1] <= side_ff[j];
         end
      end
   end

   assign out_valid = v_ff[N];
   assign root      = root_ff[N];
   assign out_side  = side_ff[N];

endmodule

// ----- rtl/core/dpsf_div.sv -----
module dpsf_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            en,
   input  logic                            in_valid,
   input  logic [dpsf_pkg::DEN_W-1:0]      rem_init,
   input  logic [dpsf_pkg::DEN_W-1:0]      den,
   input  logic [dpsf_pkg::SLOPE_W-1:0]    num_lo,
   input  dpsf_pkg::div_side_type          in_side,
   output logic                            out_valid,
   output logic [dpsf_pkg::SLOPE_W-1:0]    quo,
   output dpsf_pkg::div_side_type          out_side
);

   localparam int Q  = dpsf_pkg::SLOPE_W;
   localparam int DW = dpsf_pkg::DEN_W;

   logic [Q:0]    v_ff;
   logic [DW-1:0] rem_ff [0:Q];
   logic [DW-1:0] den_ff [0:Q];
   logic [Q-1:0]  nlo_ff [0:Q];
   logic [Q-1:0]  quo_ff [0:Q];
   dpsf_pkg::div_side_type side_ff [0:Q];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
      end
      if (en) begin
         rem_ff[0]  <= rem_init;
         den_ff[0]  <= den;
         nlo_ff[0]  <= num_lo;
         quo_ff[0]  <= '0;
         side_ff[0] <= in_side;
      end
   end

   // restoring division, one quotient bit per stage
   for (genvar j = 0; j < Q; j++) begin : g_step
      logic [DW:0] part;
      logic        take;
      assign part = {rem_ff[j], nlo_ff[j][Q-1]};
      assign take = part >= {1'b0, den_ff[j]};

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j+1] <= 1'b0;
         end else if (en) begin
            v_ff[j+1] <= v_ff[j];
         end
         if (en) begin
            rem_ff[j+1]  <= take ? DW'(part - {1'b0, den_ff[j]}) : part[DW-1:0];
            den_ff[j+1]  <= den_ff[j];
            nlo_ff[j+1]  <= nlo_ff[j] << 1;
            quo_ff[j+1]  <= {quo_ff[j][Q-2:0], take};
            side_ff[j+1] <= side_ff[j];
         end
      end
   end

   assign out_valid = v_ff[Q];
   assign quo       = quo_ff[Q];
   assign out_side  = side_ff[Q];

endmodule

// ----- rtl/core/defocus_psf_width_model.sv -----
// Defocus PSF width model. Each request carries an axial position z (nm); the block
// returns the PSF width base_sigma*sqrt(1 + sum u_i^i) in Q12.4, its slope
// d width / d z in Q15.16, an in-range flag for |z - focus_z| <= z_limit and a
// flag for a negative sum that was clamped to zero. The pipeline takes one request
// every clock cycle unless stalled and is 82 register stages deep. The depth is set by
// the three two-stage power rounds, the 33-stage square root and the 33-stage slope
// divider (one result bit per stage after its input register) plus ten further
// pipeline registers. A result that waits at the output is parked in a skid stage;
// while the skid stage is full the whole pipeline and req_tready stall. Registers
// are to be written through the csr port only while the block is idle; the block
// itself does not enforce this.
module defocus_psf_width_model #(
   parameter int MAX_TERM   = dpsf_pkg::MAX_TERM_DEF,
   parameter int FIRST_TERM = dpsf_pkg::FIRST_TERM_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] axial_pos
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [15:0] width_out, [47:16] width_slope
   output logic [1:0]  rsp_tuser,   // [0] in_range, [1] sum_clamped
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [dpsf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dpsf_pkg::CSR_DATA_W-1:0] csr_data
);

   localparam int NT = dpsf_pkg::NUM_TERMS;
   localparam int NR = dpsf_pkg::NUM_ROUNDS;

   // configuration registers
   logic [15:0] bs_ff;
   logic [15:0] fp_ff;
   logic [14:0] zl_ff;
   logic [23:0] iw_ff [0:NT-1];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bs_ff <= dpsf_pkg::BASE_SIGMA_RST;
         fp_ff <= '0;
         zl_ff <= dpsf_pkg::Z_LIMIT_RST;
         for (int l = 0; l < NT; l++) iw_ff[l] <= '0;
      end else if (csr_valid) begin
         unique case (dpsf_pkg::csr_index_type'(csr_index))
            dpsf_pkg::REG_BASE_SIGMA:  bs_ff    <= csr_data[15:0];
            dpsf_pkg::REG_FOCUS_Z:     fp_ff    <= csr_data[15:0];
            dpsf_pkg::REG_Z_LIMIT:     zl_ff    <= csr_data[14:0];
            dpsf_pkg::REG_INV_ONE:     iw_ff[0] <= csr_data;
            dpsf_pkg::REG_INV_TWO:     iw_ff[1] <= csr_data;
            dpsf_pkg::REG_INV_THREE:   iw_ff[2] <= csr_data;
            dpsf_pkg::REG_INV_FOUR:    iw_ff[3] <= csr_data;
            default: ;
         endcase
      end
   end

   logic en;
   logic skid_v_ff;
   assign en         = ~skid_v_ff;
   assign req_tready = en;

   // stage 1: offset and range check
   logic [16:0] d_c;
   logic        neg_c;
   logic [15:0] ad_c;
   assign d_c   = {req_tdata[15], req_tdata} - {fp_ff[15], fp_ff};
   assign neg_c = d_c[16];
   assign ad_c  = neg_c ? 16'(~d_c + 17'd1) : d_c[15:0];

   logic        v1_ff, neg1_ff, inr1_ff;
   logic [15:0] ad1_ff;

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (en) v1_ff <= req_tvalid;
      if (en) begin
         neg1_ff <= neg_c;
         ad1_ff  <= ad_c;
         inr1_ff <= ad_c <= {1'b0, zl_ff};
      end
   end

   // stage 2: u_i per term, then power rounds
   logic [47:0] cur_b  [0:NR][0:NT-1];
   logic [47:0] prev_b [0:NR][0:NT-1];
   logic [31:0] u_b    [0:NR][0:NT-1];
   logic        neg_b  [0:NR];
   logic        inr_b  [0:NR];
   logic        v_b    [0:NR];

   logic [39:0] ud_c [0:NT-1];
   always_comb begin
      for (int l = 0; l < NT; l++) ud_c[l] = 40'(ad1_ff) * 40'(iw_ff[l]);
   end

   always_ff @(posedge clock) begin
      if (reset) v_b[0] <= 1'b0;
      else if (en) v_b[0] <= v1_ff;
      if (en) begin
         neg_b[0] <= neg1_ff;
         inr_b[0] <= inr1_ff;
         for (int l = 0; l < NT; l++) begin
            u_b[0][l]    <= ud_c[l][39:8];
            cur_b[0][l]  <= {16'd0, ud_c[l][39:8]};
            prev_b[0][l] <= dpsf_pkg::ONE_Q16;
         end
      end
   end

   for (genvar k = 0; k < NR; k++) begin : g_round
      logic [55:0] pl_ff [0:NT-1];
      logic [55:0] ph_ff [0:NT-1];
      logic [47:0] ca_ff [0:NT-1];
      logic [47:0] pa_ff [0:NT-1];
      logic [31:0] ua_ff [0:NT-1];
      logic        na_ff, ia_ff, va_ff;
      logic [79:0] prod_c [0:NT-1];
      logic [47:0] sat_c  [0:NT-1];

      // partial products of the 48 x 32 power multiply
      always_ff @(posedge clock) begin
         if (reset) va_ff <= 1'b0;
         else if (en) va_ff <= v_b[k];
         if (en) begin
            na_ff <= neg_b[k];
            ia_ff <= inr_b[k];
            for (int l = 0; l < NT; l++) begin
               pl_ff[l] <= 56'(cur_b[k][l][23:0]) * 56'(u_b[k][l]);
               ph_ff[l] <= 56'(cur_b[k][l][47:24]) * 56'(u_b[k][l]);
               ca_ff[l] <= cur_b[k][l];
               pa_ff[l] <= prev_b[k][l];
               ua_ff[l] <= u_b[k][l];
            end
         end
      end

      always_comb begin
         for (int l = 0; l < NT; l++) begin
            prod_c[l] = {ph_ff[l], 24'd0} + {24'd0, pl_ff[l]};
            sat_c[l]  = (prod_c[l][79:16] > 64'(dpsf_pkg::PW_CAP)) ? dpsf_pkg::PW_CAP
                                                                  : prod_c[l][63:16];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) v_b[k+1] <= 1'b0;
         else if (en) v_b[k+1] <= va_ff;
         if (en) begin
            neg_b[k+1] <= na_ff;
            inr_b[k+1] <= ia_ff;
            for (int l = 0; l < NT; l++) begin
               u_b[k+1][l] <= ua_ff[l];
               // term l+1 needs l more powers
               if (k < l) begin
                  cur_b[k+1][l]  <= sat_c[l];
                  prev_b[k+1][l] <= ca_ff[l];
               end else begin
                  cur_b[k+1][l]  <= ca_ff[l];
                  prev_b[k+1][l] <= pa_ff[l];
               end
            end
         end
      end
   end

   // derivative term: power times inverse width, partial products
   logic [47:0] ql_ff [0:NT-1];
   logic [47:0] qh_ff [0:NT-1];
   logic [47:0] pt_ff [0:NT-1];
   logic        nt_ff, it_ff, vt_ff;

   always_ff @(posedge clock) begin
      if (reset) vt_ff <= 1'b0;
      else if (en) vt_ff <= v_b[NR];
      if (en) begin
         nt_ff <= neg_b[NR];
         it_ff <= inr_b[NR];
         for (int l = 0; l < NT; l++) begin
            ql_ff[l] <= 48'(prev_b[NR][l][23:0]) * 48'(iw_ff[l]);
            qh_ff[l] <= 48'(prev_b[NR][l][47:24]) * 48'(iw_ff[l]);
            pt_ff[l] <= cur_b[NR][l];
         end
      end
   end

   logic [71:0] tsum_c [0:NT-1];
   logic [66:0] ti_c   [0:NT-1];
   logic [63:0] tc_c   [0:NT-1];
   logic [49:0] sp_c   [0:NT-1];
   logic [63:0] dt_c   [0:NT-1];

   always_comb begin
      for (int l = 0; l < NT; l++) begin
         tsum_c[l] = {qh_ff[l], 24'd0} + {24'd0, ql_ff[l]};
         ti_c[l]   = 67'(tsum_c[l][71:8]) * 67'(l + 1);
         tc_c[l]   = (ti_c[l] > 67'(dpsf_pkg::DT_CAP)) ? dpsf_pkg::DT_CAP : ti_c[l][63:0];
         sp_c[l]   = '0;
         dt_c[l]   = '0;
         if ((l + 1) >= FIRST_TERM && (l + 1) <= MAX_TERM) begin
            // odd powers carry the sign of d, as do odd derivative powers
            sp_c[l] = (nt_ff && (l % 2 == 0)) ? 50'(~{2'b00, pt_ff[l]} + 50'd1)
                                              : {2'b00, pt_ff[l]};
            dt_c[l] = (nt_ff && (l % 2 == 1)) ? ~tc_c[l] + 64'd1 : tc_c[l];
         end
      end
   end

   logic [49:0] sp_ff [0:NT-1];
   logic [63:0] dt_ff [0:NT-1];
   logic        iu_ff, vu_ff;

   always_ff @(posedge clock) begin
      if (reset) vu_ff <= 1'b0;
      else if (en) vu_ff <= vt_ff;
      if (en) begin
         iu_ff <= it_ff;
         for (int l = 0; l < NT; l++) begin
            sp_ff[l] <= sp_c[l];
            dt_ff[l] <= dt_c[l];
         end
      end
   end

   // pairwise sums
   logic [50:0] s01_ff, s23_ff;
   logic [63:0] d01_ff, d23_ff;
   logic        ic_ff, vc_ff;

   always_ff @(posedge clock) begin
      if (reset) vc_ff <= 1'b0;
      else if (en) vc_ff <= vu_ff;
      if (en) begin
         ic_ff  <= iu_ff;
         s01_ff <= {sp_ff[0][49], sp_ff[0]} + {sp_ff[1][49], sp_ff[1]};
         s23_ff <= {sp_ff[2][49], sp_ff[2]} + {sp_ff[3][49], sp_ff[3]};
         d01_ff <= dt_ff[0] + dt_ff[1];
         d23_ff <= dt_ff[2] + dt_ff[3];
      end
   end

   // final sums, clamp of the scaling sum
   logic [51:0] s_c;
   logic [63:0] ds_c;
   logic        clamp_c;
   logic [47:0] sc_c;
   assign s_c     = {s01_ff[50], s01_ff} + {s23_ff[50], s23_ff} + 52'd65536;
   assign ds_c    = d01_ff + d23_ff;
   assign clamp_c = s_c[51];
   assign sc_c    = clamp_c ? 48'd0
                  : (s_c > 52'(dpsf_pkg::PW_CAP)) ? dpsf_pkg::PW_CAP : s_c[47:0];

   logic [47:0] sc_ff;
   logic [62:0] dm_ff;
   logic        dneg_ff, szero_ff, cl_ff, id_ff, vd_ff;

   always_ff @(posedge clock) begin
      if (reset) vd_ff <= 1'b0;
      else if (en) vd_ff <= vc_ff;
      if (en) begin
         sc_ff    <= sc_c;
         dneg_ff  <= ds_c[63];
         dm_ff    <= ds_c[63] ? 63'(~ds_c + 64'd1) : ds_c[62:0];
         szero_ff <= clamp_c || (ds_c == 64'd0);
         cl_ff    <= clamp_c;
         id_ff    <= ic_ff;
      end
   end

   // base_sigma times |D|, split in two partial products
   logic [47:0] mlo_ff;
   logic [46:0] mhi_ff;
   logic [63:0] xe_ff;
   logic        dneg_e_ff, szero_e_ff, cl_e_ff, ie_ff, ve_ff;

   always_ff @(posedge clock) begin
      if (reset) ve_ff <= 1'b0;
      else if (en) ve_ff <= vd_ff;
      if (en) begin
         mlo_ff     <= 48'(bs_ff) * 48'(dm_ff[31:0]);
         mhi_ff     <= 47'(bs_ff) * 47'(dm_ff[62:32]);
         xe_ff      <= {sc_ff, 16'd0};
         dneg_e_ff  <= dneg_ff;
         szero_e_ff <= szero_ff;
         cl_e_ff    <= cl_ff;
         ie_ff      <= id_ff;
      end
   end

   logic [63:0] xf_ff;
   logic        vf_ff;
   dpsf_pkg::sqrt_side_type sf_ff;

   always_ff @(posedge clock) begin
      if (reset) vf_ff <= 1'b0;
      else if (en) vf_ff <= ve_ff;
      if (en) begin
         xf_ff         <= xe_ff;
         sf_ff.num     <= {mhi_ff, 32'd0} + {31'd0, mlo_ff};
         sf_ff.dneg    <= dneg_e_ff;
         sf_ff.szero   <= szero_e_ff;
         sf_ff.clamped <= cl_e_ff;
         sf_ff.inr     <= ie_ff;
      end
   end

   logic        sq_v;
   logic [31:0] sq_root;
   dpsf_pkg::sqrt_side_type sq_side;

   dpsf_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (vf_ff),
      .radicand  (xf_ff),
      .in_side   (sf_ff),
      .out_valid (sq_v),
      .root      (sq_root),
      .out_side  (sq_side)
   );

   // width, divider set-up
   logic [47:0] wp_c;
   logic [36:0] den_c;
   assign wp_c  = 48'(bs_ff) * 48'(sq_root);
   assign den_c = {sq_root, 5'd0};

   logic        vw_ff;
   logic [36:0] rem0_ff, den_ff;
   logic [31:0] nlo_ff;
   dpsf_pkg::div_side_type sw_ff;

   always_ff @(posedge clock) begin
      if (reset) vw_ff <= 1'b0;
      else if (en) vw_ff <= sq_v;
      if (en) begin
         rem0_ff       <= sq_side.num[68:32];
         den_ff        <= den_c;
         nlo_ff        <= sq_side.num[31:0];
         sw_ff.width   <= (wp_c[47:16] > 32'h0000_FFFF) ? 16'hFFFF : wp_c[31:16];
         sw_ff.dneg    <= sq_side.dneg;
         sw_ff.zero    <= sq_side.szero || (sq_root == 32'd0);
         sw_ff.ovf     <= sq_side.num[78:32] >= {10'd0, den_c};
         sw_ff.clamped <= sq_side.clamped;
         sw_ff.inr     <= sq_side.inr;
      end
   end

   logic        dv_v;
   logic [31:0] dv_q;
   dpsf_pkg::div_side_type dv_side;

   dpsf_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (vw_ff),
      .rem_init  (rem0_ff),
      .den       (den_ff),
      .num_lo    (nlo_ff),
      .in_side   (sw_ff),
      .out_valid (dv_v),
      .quo       (dv_q),
      .out_side  (dv_side)
   );

   // slope saturation and sign
   logic [31:0] slope_c;
   always_comb begin
      priority if (dv_side.zero) begin
         slope_c = '0;
      end else if (dv_side.dneg) begin
         slope_c = (dv_side.ovf || dv_q > 32'h8000_0000) ? 32'h8000_0000 : ~dv_q + 32'd1;
      end else begin
         slope_c = (dv_side.ovf || dv_q > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : dv_q;
      end
   end

   // output register plus skid stage
   logic        out_v_ff;
   logic [47:0] out_d_ff, skid_d_ff;
   logic [1:0]  out_u_ff, skid_u_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (rsp_tready || !out_v_ff) begin
         out_v_ff  <= skid_v_ff || dv_v;
         skid_v_ff <= 1'b0;
      end else if (en && dv_v) begin
         skid_v_ff <= 1'b1;
      end
      if (rsp_tready || !out_v_ff) begin
         out_d_ff <= skid_v_ff ? skid_d_ff : {slope_c, dv_side.width};
         out_u_ff <= skid_v_ff ? skid_u_ff : {dv_side.clamped, dv_side.inr};
      end else if (en && dv_v) begin
         skid_d_ff <= {slope_c, dv_side.width};
         skid_u_ff <= {dv_side.clamped, dv_side.inr};
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_d_ff;
   assign rsp_tuser  = out_u_ff;

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid stage holds a result while output register is empty");

   a_skid_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_v_ff) |-> $past(out_v_ff && !rsp_tready))
      else $error("skid stage filled without an output stall");

   a_clamp_zero: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && out_u_ff[1]) |-> (out_d_ff == 48'd0))
      else $error("clamped sum must give zero width and slope");

endmodule

// ----- sim/psf_width_checker.sv -----
`timescale 1ns / 1ps

module psf_width_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [47:0] rsp_tdata,
   input  logic [1:0]  rsp_tuser,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [dpsf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dpsf_pkg::CSR_DATA_W-1:0] csr_data,
   output int          fail_count,
   output int          pending_count
);

   typedef struct packed {
      logic [15:0] width;
      logic [31:0] slope;
      logic        in_range;
      logic        clamped;
   } psf_result_type;

   localparam logic [63:0] POWER_CAP = 64'h0000_8000_0000_0000;
   localparam logic [63:0] TERM_CAP  = 64'h1000_0000_0000_0000;

   logic [15:0]        sigma_q;
   logic signed [15:0] focal_q;
   logic [14:0]        limit_q;
   logic [23:0]        inv_q [4];

   psf_result_type expected_results [$];

   assign pending_count = expected_results.size();

   function automatic logic [63:0] q16_mul(logic [63:0] a, logic [63:0] b);
      logic [127:0] prod;
      prod = ({64'b0, a} * {64'b0, b}) >> 16;
      return (prod > {64'b0, POWER_CAP}) ? POWER_CAP : prod[63:0];
   endfunction

   function automatic logic [63:0] floor_sqrt(logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bitv;
      res  = 0;
      bitv = 64'h4000_0000_0000_0000;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v   = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic psf_result_type predict_psf(logic [15:0] zraw);
      longint         d, ad, s, dsum;
      logic [63:0]    iw, u, pw, p, t, r, dm;
      logic [127:0]   num, q;
      logic           neg, clamped;
      psf_result_type res;
      d       = longint'($signed(zraw)) - longint'(focal_q);
      neg     = d < 0;
      ad      = neg ? -d : d;
      s       = 65536;
      dsum    = 0;
      clamped = 0;
      for (int i = 1; i <= 4; i++) begin
         iw = {40'b0, inv_q[i-1]};
         u  = (ad * iw) >> 8;
         pw = 64'd65536;
         for (int k = 0; k < i - 1; k++) pw = q16_mul(pw, u);
         p = q16_mul(pw, u);
         s = (neg && (i % 2 == 1)) ? s - longint'(p) : s + longint'(p);
         t = (pw >> 8) * iw + (((pw & 64'hFF) * iw) >> 8);
         t = (t > TERM_CAP / i) ? TERM_CAP : t * i;
         dsum = (neg && (i % 2 == 0)) ? dsum - longint'(t) : dsum + longint'(t);
      end
      if (s < 0) begin
         s       = 0;
         clamped = 1;
      end
      if (s > longint'(POWER_CAP)) s = longint'(POWER_CAP);
      r = floor_sqrt(64'(s) << 16);
      num = ({112'b0, sigma_q} * {64'b0, r}) >> 16;
      res.width = (num > 128'hFFFF) ? 16'hFFFF : num[15:0];
      res.slope = 0;
      if (!clamped && r != 0 && dsum != 0) begin
         dm  = (dsum < 0) ? 64'(-dsum) : 64'(dsum);
         num = {112'b0, sigma_q} * {64'b0, dm};
         q   = num / ({64'b0, r} << 5);
         if (dsum < 0) begin
            if (q > 128'h8000_0000) q = 128'h8000_0000;
            res.slope = 32'h0 - q[31:0];
         end else begin
            if (q > 128'h7FFF_FFFF) q = 128'h7FFF_FFFF;
            res.slope = q[31:0];
         end
      end
      res.in_range = (ad <= longint'(limit_q));
      res.clamped  = clamped;
      return res;
   endfunction

   always @(posedge clock) begin
      psf_result_type want, got;
      if (reset) begin
         sigma_q <= dpsf_pkg::BASE_SIGMA_RST;
         focal_q <= 0;
         limit_q <= dpsf_pkg::Z_LIMIT_RST;
         for (int i = 0; i < 4; i++) inv_q[i] <= 0;
         expected_results.delete();
         fail_count <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               dpsf_pkg::REG_BASE_SIGMA: sigma_q  <= csr_data[15:0];
               dpsf_pkg::REG_FOCUS_Z:    focal_q  <= csr_data[15:0];
               dpsf_pkg::REG_Z_LIMIT:    limit_q  <= csr_data[14:0];
               dpsf_pkg::REG_INV_ONE:    inv_q[0] <= csr_data;
               dpsf_pkg::REG_INV_TWO:    inv_q[1] <= csr_data;
               dpsf_pkg::REG_INV_THREE:  inv_q[2] <= csr_data;
               dpsf_pkg::REG_INV_FOUR:   inv_q[3] <= csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) expected_results.push_back(predict_psf(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[15:0], rsp_tdata[47:16], rsp_tuser[0], rsp_tuser[1]};
            if (expected_results.size() == 0) begin
               if (fail_count < 10) $display("unexpected result %h", got);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_results.pop_front();
               if (want != got) begin
                  if (fail_count < 10)
                     $display("mismatch: width %h/%h slope %h/%h in_range %b/%b clamped %b/%b",
                        want.width, got.width, want.slope, got.slope,
                        want.in_range, got.in_range, want.clamped, got.clamped);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

   localparam logic [dpsf_pkg::CSR_IDX_W-1:0] REG_UNUSED = 3'd7;
   localparam int DRAIN_CYCLES = 120;
   localparam int STALL_LIMIT  = 3000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [15:0] req_tdata = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [47:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [dpsf_pkg::CSR_IDX_W-1:0]  csr_index = 0;
   logic [dpsf_pkg::CSR_DATA_W-1:0] csr_data = 0;
   int          fail_count, pending_count;
   int          rsp_hold = 0;
   int          idle_cycles = 0;
   bit          no_gaps = 0;

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   defocus_psf_width_model u_dut (.*);

   psf_width_checker u_checker (.*);

   // result side stall, drawn once per accepted result
   always @(posedge clock)
      if (rsp_tvalid && rsp_tready) rsp_hold = no_gaps ? 0 : $urandom_range(0, 17);

   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_tready <= 0;
         rsp_hold = rsp_hold - 1;
      end else begin
         rsp_tready <= 1;
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic write_reg(logic [dpsf_pkg::CSR_IDX_W-1:0] idx,
                            logic [dpsf_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic load_settings(logic [15:0] sigma, logic [15:0] focal, logic [14:0] limit,
                                logic [23:0] i1, logic [23:0] i2, logic [23:0] i3,
                                logic [23:0] i4);
      write_reg(dpsf_pkg::REG_BASE_SIGMA, {8'($urandom_range(0, 255)), sigma});
      write_reg(dpsf_pkg::REG_FOCUS_Z, {8'h0, focal});
      write_reg(dpsf_pkg::REG_Z_LIMIT, {9'($urandom_range(0, 511)), limit});
      write_reg(dpsf_pkg::REG_INV_ONE, i1);
      write_reg(dpsf_pkg::REG_INV_TWO, i2);
      write_reg(dpsf_pkg::REG_INV_THREE, i3);
      write_reg(dpsf_pkg::REG_INV_FOUR, i4);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   task automatic send_pos(logic [15:0] z);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1;
      req_tdata  <= z;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain;
      @(negedge clock);
      req_tvalid <= 0;
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [23:0] rand_inverse;
      return 24'($urandom_range(0, 24'hFFFFFF) >> $urandom_range(0, 23));
   endfunction

   initial begin
      logic [15:0] focal;
      logic [14:0] limit;
      int          spread;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // values after reset, in-range boundaries
      send_pos(16'd0);
      send_pos(16'h8000);
      send_pos(16'h7FFF);
      send_pos(16'd1000);
      send_pos(-16'sd1000);
      send_pos(16'd1001);
      send_pos(-16'sd1001);
      drain();

      // zero sum at z = -256, negative sum below it
      write_reg(REG_UNUSED, 24'hFFFFFF);
      load_settings(16'hFFFF, 16'd0, 15'd0, 24'd65536, 24'd0, 24'd0, 24'd0);
      send_pos(-16'sd256);
      send_pos(-16'sd300);
      send_pos(16'd0);
      send_pos(16'd256);
      send_pos(16'h7FFF);
      send_pos(16'h8000);
      drain();

      // saturating sum and width
      load_settings(16'hFFFF, 16'h7FFF, 15'h7FFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                    24'hFFFFFF);
      send_pos(16'h8000);
      send_pos(16'h7FFF);
      send_pos(16'h7FFE);
      send_pos(16'd0);
      drain();

      load_settings(16'd0, 16'h8000, 15'd0, 24'd300, 24'd70, 24'd20, 24'd5);
      send_pos(16'h8000);
      send_pos(16'h8001);
      send_pos(16'h7FFF);
      drain();

      for (int phase = 0; phase < 10; phase++) begin
         no_gaps = (phase % 3 == 1);
         if (phase == 3)
            load_settings(16'h0, 16'h0, 15'h0, 24'h0, 24'h0, 24'h0, 24'h0);
         else if (phase == 6)
            load_settings(16'hFFFF, 16'hFFFF, 15'h7FFF, 24'hFFFFFF, 24'hFFFFFF,
                          24'hFFFFFF, 24'hFFFFFF);
         else
            load_settings(16'($urandom_range(0, 16'hFFFF)), 16'($urandom_range(0, 16'hFFFF)),
                          15'($urandom_range(0, 15'h7FFF)), rand_inverse(), rand_inverse(),
                          rand_inverse(), rand_inverse());
         focal = u_checker.focal_q;
         limit = u_checker.limit_q;
         spread = 2 * int'(limit) + 16;
         for (int n = 0; n < 48; n++) begin
            if ($urandom_range(0, 3) == 0)
               send_pos(16'($urandom_range(0, 16'hFFFF)));
            else
               send_pos(focal + 16'($urandom_range(0, 2 * spread)) - 16'(spread));
         end
         drain();
      end
      no_gaps = 0;

      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
